FILE: design/assert_macros.svh
// Assertion macros shared by the page table engine RTL.
// Depends on nothing; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: design/flpt_pkg.sv
// Shared constants and entry helpers for the four-level page table engine.
// No dependencies.
`default_nettype none
package flpt_pkg;
  localparam int unsigned PoolPagesDefault = 64;
  localparam int unsigned AddrW = 52;
  localparam int unsigned VaW = 48;
  localparam int unsigned FlagW = 12;
  localparam int unsigned IdxW = 9;
  localparam int unsigned EntryW = 64;

  localparam logic [1:0] OP_MAP = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_NOMAP = 2'd2;

  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitWrite = 1;
  localparam int unsigned BitHuge = 7;

  // Frame bits 51..12 of a 52-bit address
  function automatic logic [39:0] frame_of(input logic [AddrW-1:0] a);
    frame_of = a[51:12];
  endfunction

  // Level index: level 0 is the root
  function automatic logic [IdxW-1:0] level_idx(input logic [VaW-1:0] va,
                                                input logic [1:0] lvl);
    logic [IdxW-1:0] r;
    unique case (lvl)
      2'd0: r = va[47:39];
      2'd1: r = va[38:30];
      2'd2: r = va[29:21];
      default: r = va[20:12];
    endcase
    level_idx = r;
  endfunction
endpackage
`default_nettype wire

FILE: design/flpt_pool.sv
// Table pool memory: one write port, one registered read port.
// Depends on flpt_pkg for the entry width.
`default_nettype none
module flpt_pool #(
  parameter int unsigned AW = 15
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [flpt_pkg::EntryW-1:0]  wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [flpt_pkg::EntryW-1:0]  rdata
);
  logic [flpt_pkg::EntryW-1:0] mem [2**AW];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/four_level_page_table_engine.sv
// Four-level page table engine over an internal table pool memory.
// Each level read passes through S_READ and S_EVAL, and the result beat is loaded
// in S_OUT (an unused opcode goes straight there); map zeroes each newly allocated table.
// One item at a time: in_stall is high outside idle, and the next beat is taken once
// the result beat is loaded and the engine is idle; the dependent level reads set the rate.
// Reset (rst, sync): root table cleared, no beat taken; next free 1, base 0.
`default_nettype none
`include "assert_macros.svh"
module four_level_page_table_engine #(
  parameter int unsigned POOL_PAGES = flpt_pkg::PoolPagesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [51:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [47:0] virtual_address,
  input  wire logic [51:0] physical_address,
  input  wire logic [11:0] page_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [51:0]      translated_address
);
  localparam int unsigned PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned CW = $clog2(POOL_PAGES + 1);
  localparam int unsigned AW = PW + flpt_pkg::IdxW;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_READ, S_EVAL, S_ZERO, S_OUT
  } state_t;

  state_t state;
  logic [51:0] table_base;
  logic [CW-1:0] next_free;
  logic [1:0] op;
  logic [47:0] va;
  logic [51:0] pa;
  logic [11:0] fl;
  logic [1:0] lvl;
  logic [PW-1:0] page;
  logic [PW-1:0] new_page;
  logic [flpt_pkg::IdxW-1:0] zcnt;
  logic [1:0] res_status;
  logic [51:0] res_addr;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata;

  flpt_pool #(.AW(AW)) u_pool (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // Decode link in the read entry
  logic [39:0] off;
  logic link_ok;
  logic [PW-1:0] link_pg;
  logic present, huge;
  logic [flpt_pkg::IdxW-1:0] cur_idx;
  always_comb begin
    off = rdata[51:12] - table_base[51:12];
    link_ok = (off < 40'(POOL_PAGES));
    link_pg = off[PW-1:0];
    present = rdata[flpt_pkg::BitPresent];
    huge = rdata[flpt_pkg::BitHuge];
    cur_idx = flpt_pkg::level_idx(va, lvl);
    raddr = {page, cur_idx};
  end

  // Build the link to the page about to be allocated
  logic [63:0] link_entry;
  logic [39:0] link_frame;
  always_comb begin
    link_frame = table_base[51:12] + 40'(next_free);
    link_entry = {12'd0, link_frame, 12'd0};
    link_entry[flpt_pkg::BitPresent] = 1'b1;
    link_entry[flpt_pkg::BitWrite] = 1'b1;
  end

  // Memory write port
  always_comb begin
    we = 1'b0;
    waddr = {page, cur_idx};
    wdata = '0;
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = {{PW{1'b0}}, zcnt};
    end else if (state == S_ZERO) begin
      we = 1'b1;
      waddr = {new_page, zcnt};
    end else if (state == S_EVAL && lvl == 2'd3) begin
      if (op == flpt_pkg::OP_MAP) begin
        we = 1'b1;
        wdata = {12'd0, pa[51:12], fl | 12'd1};
      end else if (op == flpt_pkg::OP_UNMAP) begin
        we = 1'b1;
      end
    end else if (state == S_EVAL && op == flpt_pkg::OP_MAP && !present
                 && next_free != CW'(POOL_PAGES)) begin
      we = 1'b1;
      wdata = link_entry;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      zcnt <= '0;
      next_free <= CW'(1);
      table_base <= '0;
      out_valid <= 1'b0;
      lvl <= '0;
      page <= '0;
      new_page <= '0;
    end else begin
      if (cfg_we) table_base <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          zcnt <= zcnt + 1'b1;
          if (&zcnt) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode;
            va <= virtual_address;
            pa <= physical_address;
            fl <= page_flags;
            lvl <= '0;
            page <= '0;
            res_status <= flpt_pkg::ST_DONE;
            res_addr <= '0;
            if (opcode == flpt_pkg::OP_MAP || opcode == flpt_pkg::OP_UNMAP
                || opcode == flpt_pkg::OP_XLATE) state <= S_READ;
            else state <= S_OUT;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (lvl == 2'd3) begin
            if (op == flpt_pkg::OP_XLATE) begin
              if (present) res_addr <= {rdata[51:12], va[11:0]};
              else res_status <= flpt_pkg::ST_NOMAP;
            end
            state <= S_OUT;
          end else if (op == flpt_pkg::OP_MAP) begin
            if (present) begin
              if (huge || !link_ok) begin
                res_status <= flpt_pkg::ST_FAIL;
                state <= S_OUT;
              end else begin
                page <= link_pg;
                lvl <= lvl + 1'b1;
                state <= S_READ;
              end
            end else if (next_free == CW'(POOL_PAGES)) begin
              res_status <= flpt_pkg::ST_FAIL;
              state <= S_OUT;
            end else begin
              new_page <= next_free[PW-1:0];
              next_free <= next_free + 1'b1;
              zcnt <= '0;
              state <= S_ZERO;
            end
          end else if (op == flpt_pkg::OP_XLATE && lvl == 2'd2 && present && huge) begin
            // Huge page: frame plus 21-bit offset, wrapped to 52 bits
            res_addr <= {rdata[51:12], 12'd0} + {31'd0, va[20:0]};
            state <= S_OUT;
          end else if (present && link_ok) begin
            page <= link_pg;
            lvl <= lvl + 1'b1;
            state <= S_READ;
          end else begin
            if (op == flpt_pkg::OP_XLATE) res_status <= flpt_pkg::ST_NOMAP;
            state <= S_OUT;
          end
        end
        S_ZERO: begin
          zcnt <= zcnt + 1'b1;
          if (&zcnt) begin
            page <= new_page;
            lvl <= lvl + 1'b1;
            state <= S_READ;
          end
        end
        S_OUT: begin
          // Load the result beat once the previous one has left
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status <= res_status;
            translated_address <= res_addr;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_alloc_bound, clk, rst, next_free <= CW'(POOL_PAGES))
  `ASSERT_CLK(a_idle_accept, clk, rst, (state == S_IDLE) |-> !in_stall)
  `ASSERT_CLK(a_zero_page, clk, rst, (state == S_ZERO) |-> (new_page != '0))
endmodule
`default_nettype wire
